### hdl/pid_controller_clamped_defines.svh
// Assertion macros shared by the clamped PID controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Implication in the same cycle, disabled during reset.
`define PID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid assertion failed");

// Implication in the next cycle, disabled during reset.
`define PID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid assertion failed");

`else

`define PID_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PID_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/pid_pkg.sv
// Shared types and constants for the clamped PID controller.
// No dependencies; used by the controller, datapath and divider.
`timescale 1ns / 1ps

package pid_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_GAIN_P  = 2'd0;
    localparam logic [1:0] REG_GAIN_I  = 2'd1;
    localparam logic [1:0] REG_GAIN_D  = 2'd2;
    localparam logic [1:0] REG_MAX_OUT = 2'd3;

    localparam logic [15:0] RST_GAIN_P  = 16'd1792;
    localparam logic [15:0] RST_GAIN_I  = 16'd1536;
    localparam logic [15:0] RST_GAIN_D  = 16'd768;
    localparam logic [14:0] RST_MAX_OUT = 15'd255;

    // Shared multiplier operand selects
    localparam logic [2:0] MUL_ERR_DT = 3'd0;
    localparam logic [2:0] MUL_ILO    = 3'd1;
    localparam logic [2:0] MUL_IHI    = 3'd2;
    localparam logic [2:0] MUL_P      = 3'd3;
    localparam logic [2:0] MUL_D      = 3'd4;

    // Accumulator operations
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_ITERM = 2'd2;
    localparam logic [1:0] ACC_ADD   = 2'd3;

    localparam int DIV_STEPS = 16;

    localparam logic signed [47:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] INTEG_MIN = 48'sh8000_0000_0000;
    localparam logic signed [63:0] ITERM_LIM = 64'sh0000_0100_0000_0000;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       integ_upd;
        logic [1:0] acc_op;
        logic       div_start;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_stat;

endpackage

### hdl/pid_controller_clamped.sv
// Clamped PID controller, top level: sequencer plus datapath.
// From request accept to o_out_valid the sequencer waits on the 16-step derivative
// divider, except with zero elapsed time, when the divider does not run.
// One request in flight: a new one is taken only once the last is done, also while
// a finished result still waits in the output register.
// Reset (synchronous, active low) restores default gains and clears the state.
`timescale 1ns / 1ps

module pid_controller_clamped (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_target_value,
    input  logic signed [15:0] i_measured_value,
    input  logic [31:0]        i_now_us,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_drive_out,
    output logic               o_clamped
);
    import pid_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: walks one request through the shared multiplier in this order:
    // error*dt into the saturating integral, integral*Ki in two halves, limit,
    // add error*Kp, wait for the divider, add derivative*Kd, clamp and hold
    // the result until the output register is free.
    pid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: configuration registers, integral, last timestamp, previous
    // measurement, one 33x17 multiplier with registered product, a 43-bit
    // accumulator in Q27.16 and the output register.
    pid_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_target_value   (i_target_value),
        .i_measured_value (i_measured_value),
        .i_now_us         (i_now_us),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_drive_out      (o_drive_out),
        .o_clamped        (o_clamped)
    );

endmodule

### hdl/pid_div.sv
// Restoring divider for the derivative term: 17-bit signed dividend by 32-bit
// unsigned divisor, truncated toward zero, one quotient bit per cycle. Uses pid_pkg.
`timescale 1ns / 1ps

module pid_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_num,
    input  logic [31:0]        i_den,
    output logic               o_busy,
    output logic signed [16:0] o_quot
);
    import pid_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [15:0]      r_num;
    logic [31:0]      r_den;
    logic [31:0]      r_rem;
    logic [15:0]      r_q;

    logic [16:0] num_mag;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;
    logic [31:0] n_rem;

    always_comb begin
        num_mag = i_num[16] ? (17'd0 - i_num) : i_num;
        rem_sh  = {r_rem, r_num[15]};
        ge      = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
        n_rem   = ge ? rem_sub[31:0] : rem_sh[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_den != 32'd0);
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[16];
            r_num <= num_mag[15:0];
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[14:0], 1'b0};
            r_q   <= {r_q[14:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? (17'sd0 - $signed({1'b0, r_q})) : $signed({1'b0, r_q});

endmodule

### hdl/pid_dpath.sv
// Datapath of the clamped PID controller: configuration registers, loop state,
// shared 33x17 multiplier, accumulator, output clamp. Uses pid_pkg and pid_div.
`timescale 1ns / 1ps

module pid_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic signed [15:0] i_target_value,
    input  logic signed [15:0] i_measured_value,
    input  logic [31:0]        i_now_us,
    input  pid_pkg::t_cmd      i_cmd,
    output pid_pkg::t_stat     o_stat,
    output logic signed [15:0] o_drive_out,
    output logic               o_clamped
);
    import pid_pkg::*;

    logic [15:0]        r_gain_p;
    logic [15:0]        r_gain_i;
    logic [15:0]        r_gain_d;
    logic [14:0]        r_max_out;
    logic signed [47:0] r_integ;
    logic [31:0]        r_last_ts;
    logic signed [15:0] r_prev_meas;

    logic signed [16:0] r_err;
    logic signed [16:0] r_dnum;
    logic [31:0]        r_dt;
    logic signed [49:0] r_prod;
    logic signed [42:0] r_acc;
    logic signed [15:0] r_drive;
    logic               r_clamped;

    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_res;
    logic signed [50:0] integ_sum;
    logic signed [47:0] n_integ;
    logic signed [63:0] iterm;
    logic signed [63:0] iterm_sat;
    logic signed [42:0] lim;
    logic signed [42:0] n_acc;
    logic signed [15:0] n_drive;
    logic               n_clamped;
    logic signed [16:0] quot;
    logic               div_busy;

    // Derivative divider
    pid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_dnum),
        .i_den   (r_dt),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign o_stat.div_busy = div_busy;

    // Operand select for the shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ERR_DT: begin
                mul_a = $signed({1'b0, r_dt});
                mul_b = r_err;
            end
            MUL_ILO: begin
                mul_a = $signed({9'd0, r_integ[23:0]});
                mul_b = $signed({1'b0, r_gain_i});
            end
            MUL_IHI: begin
                mul_a = {{9{r_integ[47]}}, r_integ[47:24]};
                mul_b = $signed({1'b0, r_gain_i});
            end
            MUL_P: begin
                mul_a = {{16{r_err[16]}}, r_err};
                mul_b = $signed({1'b0, r_gain_p});
            end
            MUL_D: begin
                mul_a = {{16{quot[16]}}, quot};
                mul_b = $signed({1'b0, r_gain_d});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    // Saturating integral update
    always_comb begin
        integ_sum = {{3{r_integ[47]}}, r_integ} + {r_prod[49], r_prod};
        if (integ_sum[50:47] == 4'b0000 || integ_sum[50:47] == 4'b1111) begin
            n_integ = integ_sum[47:0];
        end else if (integ_sum[50]) begin
            n_integ = INTEG_MIN;
        end else begin
            n_integ = INTEG_MAX;
        end
    end

    // Accumulator: integral term is hi*gain<<24 + lo*gain, then limited
    always_comb begin
        iterm = ({{14{r_prod[49]}}, r_prod} <<< 24) + {{21{r_acc[42]}}, r_acc};
        if (iterm > ITERM_LIM) begin
            iterm_sat = ITERM_LIM;
        end else if (iterm < -ITERM_LIM) begin
            iterm_sat = -ITERM_LIM;
        end else begin
            iterm_sat = iterm;
        end
        case (i_cmd.acc_op)
            ACC_LOAD:  n_acc = r_prod[42:0];
            ACC_ITERM: n_acc = iterm_sat[42:0];
            ACC_ADD:   n_acc = r_acc + r_prod[42:0];
            default:   n_acc = r_acc;
        endcase
    end

    // Output clamp, floor of Q27.16 sum otherwise
    always_comb begin
        lim = $signed({12'd0, r_max_out, 16'd0});
        if (r_acc > lim) begin
            n_drive   = $signed({1'b0, r_max_out});
            n_clamped = 1'b1;
        end else if (r_acc < -lim) begin
            n_drive   = 16'sd0 - $signed({1'b0, r_max_out});
            n_clamped = 1'b1;
        end else begin
            n_drive   = r_acc[31:16];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= RST_GAIN_P;
            r_gain_i    <= RST_GAIN_I;
            r_gain_d    <= RST_GAIN_D;
            r_max_out   <= RST_MAX_OUT;
            r_integ     <= '0;
            r_last_ts   <= '0;
            r_prev_meas <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN_P:  r_gain_p  <= i_cfg_data;
                    REG_GAIN_I:  r_gain_i  <= i_cfg_data;
                    REG_GAIN_D:  r_gain_d  <= i_cfg_data;
                    REG_MAX_OUT: r_max_out <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_in) begin
                r_last_ts   <= i_now_us;
                r_prev_meas <= i_measured_value;
            end
            if (i_cmd.integ_upd) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_err  <= {i_target_value[15], i_target_value}
                      - {i_measured_value[15], i_measured_value};
            r_dnum <= {r_prev_meas[15], r_prev_meas}
                      - {i_measured_value[15], i_measured_value};
            r_dt   <= i_now_us - r_last_ts;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_res;
        end
        r_acc <= n_acc;
        if (i_cmd.out_load) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_drive_out = r_drive;
    assign o_clamped   = r_clamped;

endmodule

### hdl/pid_ctrl.sv
// Sequencer of the clamped PID controller: steps the datapath through one
// request and owns both handshakes. Uses pid_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "pid_controller_clamped_defines.svh"

module pid_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pid_pkg::t_stat i_stat,
    output pid_pkg::t_cmd  o_cmd
);
    import pid_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MI   = 4'd1;
    localparam logic [3:0] S_IACC = 4'd2;
    localparam logic [3:0] S_MLO  = 4'd3;
    localparam logic [3:0] S_MHI  = 4'd4;
    localparam logic [3:0] S_IT   = 4'd5;
    localparam logic [3:0] S_P    = 4'd6;
    localparam logic [3:0] S_WDIV = 4'd7;
    localparam logic [3:0] S_D    = 4'd8;
    localparam logic [3:0] S_DA   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    t_cmd       cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_MI;
                end
            end
            S_MI: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_ERR_DT;
                cmd.div_start = 1'b1;
                n_state       = S_IACC;
            end
            S_IACC: begin
                cmd.integ_upd = 1'b1;
                n_state       = S_MLO;
            end
            S_MLO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ILO;
                n_state     = S_MHI;
            end
            S_MHI: begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_IHI;
                n_state     = S_IT;
            end
            S_IT: begin
                cmd.acc_op  = ACC_ITERM;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                n_state     = S_P;
            end
            S_P: begin
                cmd.acc_op = ACC_ADD;
                n_state    = S_WDIV;
            end
            S_WDIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_D;
                end
            end
            S_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                n_state     = S_DA;
            end
            S_DA: begin
                cmd.acc_op = ACC_ADD;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `PID_ASSERT_NOW(a_load_free, i_clk, i_rst_n, cmd.out_load, !r_out_valid || i_out_ready)
    `PID_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, cmd.div_start, !i_stat.div_busy)
    `PID_ASSERT_NEXT(a_wait_div, i_clk, i_rst_n, r_state == S_WDIV && i_stat.div_busy, r_state == S_WDIV)
    `PID_ASSERT_NEXT(a_accept_go, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_MI && !o_in_ready)

endmodule
